### src/interval_set_engine_defines.svh
// Assertion macros used by the interval set engine sequencer.
`ifndef INTERVAL_SET_ENGINE_DEFINES_SVH
`define INTERVAL_SET_ENGINE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define ISE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ISE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/ise_pkg.sv
// Types and constants of the interval set engine.
package ise_pkg;

	localparam int FIELD_BITS = 16;
	localparam int COUNT_BITS = 6;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]            mode;
		logic [FIELD_BITS-1:0] range_start;
		logic [FIELD_BITS-1:0] range_end;
	} req_t;

	typedef struct packed {
		logic                  any_present;
		logic                  all_present;
		logic [COUNT_BITS-1:0] range_count;
		logic                  rejected;
	} rsp_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic done;
		rsp_t rsp;
	} ctrl_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_SHIFT,
		S_W0,
		S_W1,
		S_FINISH
	} state_t;

endpackage

### src/ise_mem.sv
// Range table memory: one write port, one registered read port.
module ise_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/ise_ctrl.sv
// Sequencer: scans the range table, then for a table change shifts entries and writes new pieces.
module ise_ctrl #(
	parameter int MAX_RANGES = 32,
	parameter int INDEX_BITS = 16,
	parameter int AW         = 5,
	parameter int CW         = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  ise_pkg::req_t          req,
	output logic                   idle,
	input  logic                   slot_free,
	output ise_pkg::ctrl_out_t     status,
	output logic [AW-1:0]          mem_raddr,
	input  logic [2*INDEX_BITS-1:0] mem_rdata,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [2*INDEX_BITS-1:0] mem_wdata
);
	import ise_pkg::*;
	`include "interval_set_engine_defines.svh"

	localparam int IB = INDEX_BITS;

	state_t state_q, state_d;

	logic [1:0]    mode_q;
	logic [IB-1:0] b_q, e_q;
	logic [CW-1:0] count_q, lo_q, hi_q, rk_q, sk_q, rem_q;
	logic          seen_lo_q, up_q;
	logic [IB-1:0] start_lo_q, end_hi_q;
	logic          any_q, all_q, rej_q;
	logic [1:0]    np_q;
	logic [IB-1:0] p0s_q, p0e_q, p1s_q, p1e_q;
	logic          vld_s1;
	logic [CW-1:0] k_s1;

	// masked input indices
	logic [31:0]   s32, e32;
	logic [IB-1:0] in_b, in_e;
	assign s32  = {16'b0, req.range_start};
	assign e32  = {16'b0, req.range_end};
	assign in_b = s32[IB-1:0];
	assign in_e = e32[IB-1:0];

	// entry on the read port
	logic [IB-1:0] ent_s, ent_e;
	assign ent_s = mem_rdata[2*IB-1:IB];
	assign ent_e = mem_rdata[IB-1:0];

	// per-entry compares
	logic c_lo, c_hi;
	always_comb begin
		if (mode_q == MODE_ADD) begin
			c_lo = ent_e < b_q;
			c_hi = ent_s <= e_q;
		end else begin
			c_lo = ent_e <= b_q;
			c_hi = ent_s < e_q;
		end
	end

	// replacement pieces and new count
	logic [1:0]    np;
	logic [IB-1:0] p0s, p0e, p1s, p1e;
	logic [CW:0]   total;
	logic [CW-1:0] removed;
	always_comb begin
		np  = 2'd0;
		p0s = b_q;
		p0e = e_q;
		p1s = e_q;
		p1e = end_hi_q;
		if (mode_q == MODE_ADD) begin
			np = 2'd1;
			if (lo_q != hi_q) begin
				p0s = (start_lo_q < b_q) ? start_lo_q : b_q;
				p0e = (end_hi_q > e_q) ? end_hi_q : e_q;
			end
		end else begin
			if (start_lo_q < b_q) begin
				p0s = start_lo_q;
				p0e = b_q;
				np  = 2'd1;
				if (end_hi_q > e_q) begin
					np = 2'd2;
				end
			end else if (end_hi_q > e_q) begin
				p0s = e_q;
				p0e = end_hi_q;
				np  = 2'd1;
			end
		end
		removed = hi_q - lo_q;
		total   = {1'b0, lo_q} + (CW+1)'(np) + {1'b0, count_q} - {1'b0, hi_q};
	end

	logic eval_noop, eval_reject;
	assign eval_noop   = (mode_q == MODE_REMOVE) && (lo_q == hi_q);
	assign eval_reject = total > (CW+1)'(MAX_RANGES);

	// destination of a moved entry and slot of the second new piece
	logic [CW-1:0] shift_dst, lo_next;
	assign shift_dst = k_s1 - hi_q + lo_q + CW'(np_q);
	assign lo_next   = lo_q + CW'(1);

	// next state and memory strobes
	always_comb begin
		state_d   = state_q;
		mem_raddr = rk_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = lo_q[AW-1:0];
		mem_wdata = {p0s_q, p0e_q};
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if ((req.mode == MODE_ADD || req.mode == MODE_REMOVE ||
					     req.mode == MODE_QUERY) && in_b < in_e) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				mem_raddr = rk_q[AW-1:0];
				if (rk_q == count_q && !vld_s1) begin
					state_d = (mode_q == MODE_QUERY) ? S_FINISH : S_EVAL;
				end
			end
			S_EVAL: begin
				if (eval_noop || eval_reject) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				mem_raddr = sk_q[AW-1:0];
				mem_we    = vld_s1;
				mem_waddr = shift_dst[AW-1:0];
				mem_wdata = mem_rdata;
				if (rem_q == '0 && !vld_s1) begin
					state_d = (np_q == 2'd0) ? S_FINISH : S_W0;
				end
			end
			S_W0: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[AW-1:0];
				mem_wdata = {p0s_q, p0e_q};
				state_d   = (np_q == 2'd2) ? S_W1 : S_FINISH;
			end
			S_W1: begin
				mem_we    = 1'b1;
				mem_waddr = lo_next[AW-1:0];
				mem_wdata = {p1s_q, p1e_q};
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
			rk_q    <= '0;
			sk_q    <= '0;
			rem_q   <= '0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					rk_q <= '0;
				end
				S_SCAN: begin
					if (rk_q != count_q) begin
						vld_s1 <= 1'b1;
						rk_q   <= rk_q + CW'(1);
					end
				end
				S_EVAL: begin
					if (!eval_noop && !eval_reject) begin
						count_q <= total[CW-1:0];
						rem_q   <= count_q - hi_q;
						sk_q    <= (CW'(np) > removed) ? count_q - CW'(1) : hi_q;
					end
				end
				S_SHIFT: begin
					if (rem_q != '0) begin
						vld_s1 <= 1'b1;
						rem_q  <= rem_q - CW'(1);
						sk_q   <= up_q ? sk_q - CW'(1) : sk_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		k_s1 <= (state_q == S_SHIFT) ? sk_q : rk_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_q    <= req.mode;
					b_q       <= in_b;
					e_q       <= in_e;
					lo_q      <= '0;
					hi_q      <= '0;
					seen_lo_q <= 1'b0;
					any_q     <= 1'b0;
					all_q     <= (req.mode == MODE_QUERY) && !(in_b < in_e);
					rej_q     <= 1'b0;
				end
			end
			S_SCAN: begin
				if (vld_s1) begin
					if (c_lo) begin
						lo_q <= lo_q + CW'(1);
					end else if (!seen_lo_q) begin
						seen_lo_q  <= 1'b1;
						start_lo_q <= ent_s;
					end
					if (c_hi) begin
						hi_q     <= hi_q + CW'(1);
						end_hi_q <= ent_e;
					end
					if (mode_q == MODE_QUERY) begin
						if (ent_s < e_q && ent_e > b_q) begin
							any_q <= 1'b1;
						end
						if (ent_s <= b_q && ent_e >= e_q) begin
							all_q <= 1'b1;
						end
					end
				end
			end
			S_EVAL: begin
				rej_q <= !eval_noop && eval_reject;
				np_q  <= np;
				up_q  <= CW'(np) > removed;
				p0s_q <= p0s;
				p0e_q <= p0e;
				p1s_q <= p1s;
				p1e_q <= p1e;
			end
			default: ;
		endcase
	end

	// result toward the output register
	logic [31:0] cnt32;
	assign cnt32                     = 32'(count_q);
	assign idle                      = (state_q == S_IDLE);
	assign status.done               = (state_q == S_FINISH) && slot_free;
	assign status.rsp.any_present    = any_q && (mode_q == MODE_QUERY);
	assign status.rsp.all_present    = all_q && (mode_q == MODE_QUERY);
	assign status.rsp.range_count    = cnt32[COUNT_BITS-1:0];
	assign status.rsp.rejected       = rej_q && (mode_q == MODE_ADD || mode_q == MODE_REMOVE);

	`ISE_ASSERT(a_count_cap, count_q <= CW'(MAX_RANGES), "range count above capacity")
	`ISE_ASSERT(a_no_write_idle, !(state_q == S_IDLE && mem_we), "table write while idle")
	`ISE_ASSERT_NEXT(a_done_idle, status.done, state_q == S_IDLE, "no return to idle after result")
	`ISE_ASSERT(a_waddr_range, !mem_we || mem_waddr <= AW'(MAX_RANGES - 1), "table write beyond capacity")

endmodule

### src/interval_set_engine.sv
// Interval set engine top level: sequencer, range table and output register.
//
// Keeps a sorted set of disjoint half-open index ranges in one table memory.
// Input channel req (req_valid/req_ready) carries mode, range_start, range_end;
// output channel rsp (rsp_valid/rsp_ready) returns one result item per item.
// Add merges the range into the set, remove cuts it out, query reports whether
// any and whether all of its indices are present.
// An item first scans the table, reading one entry per cycle. An add or remove
// is then decided; if it changes the table, the tail (from hi, the first entry
// past the range) is moved and each new piece is written. Every item ends by
// handing off its result, which shows on rsp the next cycle.
// One item is in work at a time; req_ready is high while the sequencer is idle.
// A finished result sits in the output register; the next item is taken while
// it waits. If the receiver stalls with a result still held, the following
// result waits in the sequencer and no new item is accepted.
// Reset empties the set at once (count cleared); the table needs no clearing.
module interval_set_engine #(
	parameter int MAX_RANGES = 32,
	parameter int INDEX_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ise_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ise_pkg::rsp_t rsp
);
	import ise_pkg::*;

	localparam int AW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int DW = 2 * INDEX_BITS;

	logic          idle, slot_free;
	ctrl_out_t     status;
	logic [AW-1:0] raddr, waddr;
	logic [DW-1:0] rdata, wdata;
	logic          we;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	assign req_ready = idle;
	assign slot_free = !rsp_valid_q || rsp_ready;

	ise_ctrl #(
		.MAX_RANGES(MAX_RANGES),
		.INDEX_BITS(INDEX_BITS),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(req_valid && req_ready),
		.req(req),
		.idle(idle),
		.slot_free(slot_free),
		.status(status),
		.mem_raddr(raddr),
		.mem_rdata(rdata),
		.mem_we(we),
		.mem_waddr(waddr),
		.mem_wdata(wdata)
	);

	ise_mem #(
		.DEPTH(MAX_RANGES),
		.AW(AW),
		.DW(DW)
	) u_mem (
		.clk(clk),
		.raddr(raddr),
		.rdata(rdata),
		.we(we),
		.waddr(waddr),
		.wdata(wdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (status.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			rsp_q <= status.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### tb/tb_interval_set_engine.sv
// Self-checking testbench of the interval set engine: directed and random add, remove, query and invalid items.
`timescale 1ns / 100ps

module tb_interval_set_engine;
	import ise_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	interval_set_engine dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Predictor state: sorted disjoint ranges
	int unsigned set_lo[$];
	int unsigned set_hi[$];
	req_t pending_items[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	bit stimulus_done = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	int rx_count = 0;

	// Replace entries [lo, hi) with the given pieces if they fit
	function automatic bit splice_ranges(int lo, int hi, int unsigned ps[$], int unsigned pe[$]);
		int total;
		total = lo + ps.size() + (set_lo.size() - hi);
		if (total > TABLE_DEPTH)
			return 0;
		for (int k = lo; k < hi; k++) begin
			set_lo.delete(lo);
			set_hi.delete(lo);
		end
		for (int k = ps.size() - 1; k >= 0; k--) begin
			set_lo.insert(lo, ps[k]);
			set_hi.insert(lo, pe[k]);
		end
		return 1;
	endfunction

	function automatic rsp_t predict_rsp(req_t it);
		rsp_t r;
		int unsigned b, e;
		int lo, hi, n;
		int unsigned ps[$];
		int unsigned pe[$];
		r = '0;
		b = it.range_start;
		e = it.range_end;
		n = set_lo.size();
		lo = 0;
		if (it.mode == MODE_ADD && b < e) begin
			while (lo < n && set_hi[lo] < b) lo++;
			hi = lo;
			while (hi < n && set_lo[hi] <= e) hi++;
			if (lo == hi) begin
				ps.insert(ps.size(), b); pe.insert(pe.size(), e);
			end else begin
				ps.insert(ps.size(), set_lo[lo] < b ? set_lo[lo] : b);
				pe.insert(pe.size(), set_hi[hi-1] > e ? set_hi[hi-1] : e);
			end
			r.rejected = !splice_ranges(lo, hi, ps, pe);
		end else if (it.mode == MODE_REMOVE && b < e) begin
			while (lo < n && set_hi[lo] <= b) lo++;
			hi = lo;
			while (hi < n && set_lo[hi] < e) hi++;
			if (lo != hi) begin
				if (set_lo[lo] < b) begin
					ps.insert(ps.size(), set_lo[lo]); pe.insert(pe.size(), b);
				end
				if (set_hi[hi-1] > e) begin
					ps.insert(ps.size(), e); pe.insert(pe.size(), set_hi[hi-1]);
				end
				r.rejected = !splice_ranges(lo, hi, ps, pe);
			end
		end else if (it.mode == MODE_QUERY) begin
			if (b >= e)
				r.all_present = 1'b1;
			else
				foreach (set_lo[k]) begin
					if (set_lo[k] < e && set_hi[k] > b) r.any_present = 1'b1;
					if (set_lo[k] <= b && set_hi[k] >= e) r.all_present = 1'b1;
				end
		end
		r.range_count = COUNT_BITS'(set_lo.size());
		return r;
	endfunction

	function automatic req_t make_item(logic [1:0] m, int unsigned b, int unsigned e);
		req_t it;
		it.mode = m;
		it.range_start = FIELD_BITS'(b);
		it.range_end = FIELD_BITS'(e);
		return it;
	endfunction

	// Append an item to the stimulus queue
	function automatic void enqueue(req_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Ranges mostly in a small window so they collide; some full-width, some malformed
	function automatic req_t random_item();
		int unsigned b, w, sel;
		logic [1:0] m;
		sel = $urandom_range(0, 99);
		if (sel < 40) m = MODE_ADD;
		else if (sel < 65) m = MODE_REMOVE;
		else if (sel < 97) m = MODE_QUERY;
		else m = 2'd3;
		sel = $urandom_range(0, 99);
		if (sel < 75) begin
			b = $urandom_range(0, 600);
			w = $urandom_range(0, 12);
			return make_item(m, b, b + w);
		end else if (sel < 90) begin
			b = $urandom_range(0, 65535);
			return make_item(m, b, b + $urandom_range(0, 65535 - b));
		end
		return make_item(m, $urandom_range(0, 65535), $urandom_range(0, 65535));
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Stimulus: directed cases, then random
	initial begin
		arst_n = 0;
		enqueue(make_item(MODE_QUERY, 0, 0));
		enqueue(make_item(MODE_QUERY, 5, 3));
		enqueue(make_item(MODE_ADD, 9, 4));
		enqueue(make_item(MODE_ADD, 10, 20));
		enqueue(make_item(MODE_ADD, 20, 30));
		enqueue(make_item(MODE_ADD, 40, 50));
		enqueue(make_item(MODE_QUERY, 15, 45));
		enqueue(make_item(MODE_QUERY, 12, 28));
		enqueue(make_item(MODE_REMOVE, 14, 16));
		enqueue(make_item(MODE_REMOVE, 60, 70));
		enqueue(make_item(MODE_REMOVE, 30, 40));
		enqueue(make_item(2'd3, 1, 2));
		enqueue(make_item(MODE_ADD, 0, 16'hFFFF));
		enqueue(make_item(MODE_QUERY, 16'hFFFE, 16'hFFFF));
		enqueue(make_item(MODE_REMOVE, 0, 16'hFFFF));
		// Fill the table to capacity, then force a rejection
		for (int k = 0; k < TABLE_DEPTH; k++)
			enqueue(make_item(MODE_ADD, 4 * k, 4 * k + 2));
		enqueue(make_item(MODE_ADD, 16'hFF00, 16'hFF10));
		enqueue(make_item(MODE_REMOVE, 4, 5));
		enqueue(make_item(MODE_ADD, 2, 4));
		enqueue(make_item(MODE_REMOVE, 0, 16'hFFFF));
		for (int k = 0; k < 800; k++)
			enqueue(random_item());
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// Driver
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 0;
			tx_gap <= 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_rsps.insert(expected_rsps.size(), predict_rsp(req));
			end
			if (req_valid && !req_ready) begin
				// hold item
			end else if (tx_gap > 0) begin
				req_valid <= 0;
				tx_gap <= tx_gap - 1;
			end else if (pending_items.size() > 0) begin
				req <= pending_items.pop_front();
				req_valid <= 1;
				tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			end else begin
				req_valid <= 0;
				stimulus_done <= 1;
			end
		end
	end

	// Monitor and receiver stall control
	int rx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 0;
			rx_gap <= 0;
			hold_off <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rx_count <= rx_count + 1;
				if (expected_rsps.size() == 0) begin
					$error("unexpected result item");
					errors++;
				end else begin
					rsp_t x;
					x = expected_rsps.pop_front();
					if (rsp.any_present !== x.any_present) begin
						$error("any_present: expected %0d actual %0d", x.any_present, rsp.any_present);
						errors++;
					end
					if (rsp.all_present !== x.all_present) begin
						$error("all_present: expected %0d actual %0d", x.all_present, rsp.all_present);
						errors++;
					end
					if (rsp.range_count !== x.range_count) begin
						$error("range_count: expected %0d actual %0d", x.range_count, rsp.range_count);
						errors++;
					end
					if (rsp.rejected !== x.rejected) begin
						$error("rejected: expected %0d actual %0d", x.rejected, rsp.rejected);
						errors++;
					end
				end
			end
			if (rx_count == 100 && hold_off == 0) begin
				// long hold-off so the block backs up
				rsp_ready <= 0;
				hold_off <= 1;
			end else if (hold_off > 0 && hold_off < 600) begin
				rsp_ready <= 0;
				hold_off <= hold_off + 1;
			end else if (rsp_valid && rsp_ready) begin
				rx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				rsp_ready <= 0;
				if (hold_off == 600) hold_off <= 601;
			end else if (rx_gap > 0) begin
				rsp_ready <= 0;
				rx_gap <= rx_gap - 1;
			end else begin
				rsp_ready <= 1;
				if (hold_off == 600) hold_off <= 601;
			end
		end
	end

	// Watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End of run
	initial begin
		@(posedge arst_n);
		while (!(stimulus_done && expected_rsps.size() == 0) && idle_cycles < STALL_LIMIT)
			@(posedge clk);
		if (idle_cycles >= STALL_LIMIT) begin
			$display("interval_set_engine regression: fail");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			if (errors == 0 && expected_rsps.size() == 0 && !rsp_valid)
				$display("interval_set_engine regression: pass");
			else
				$display("interval_set_engine regression: fail");
			$finish;
		end
	end

endmodule

### sim.f
+incdir+src
src/ise_pkg.sv
src/ise_mem.sv
src/ise_ctrl.sv
src/interval_set_engine.sv
tb/tb_interval_set_engine.sv
